[sv/lsb_stego_stream_decoder_top_macros.svh]
// Assertion helpers for the LSB stego stream decoder.
// Each helper names its check, samples on clk and holds off while rst is high.
`ifndef LSB_STEGO_STREAM_DECODER_TOP_MACROS_SVH
`define LSB_STEGO_STREAM_DECODER_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define LSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define LSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LSD_ASSERT_IMP(lbl, ante, cons, msg)
`define LSD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[sv/lsd_pkg.sv]
`timescale 1ns / 1ps
package lsd_pkg;

  // Payload widths
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int SKIP_W  = 16;
  localparam int WORD_W  = 32;
  localparam int BIT_W   = 5;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Parse phases
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_MAGIC   = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_EXT     = 3'd3;
  localparam logic [2:0] PH_PAYLEN  = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_IDLE    = 3'd6;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_EXT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_END = 2'd3;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_HEADER_SKIP  = 2'd0;
  localparam logic [1:0] REG_MAGIC_CHAR_A = 2'd1;
  localparam logic [1:0] REG_MAGIC_CHAR_B = 2'd2;

  // Register reset values
  localparam logic [SKIP_W-1:0] HEADER_SKIP_RST  = 16'd54;
  localparam logic [BYTE_W-1:0] MAGIC_CHAR_A_RST = 8'd35;
  localparam logic [BYTE_W-1:0] MAGIC_CHAR_B_RST = 8'd42;

  // Last bit index of a byte and of a length word
  localparam logic [BIT_W-1:0] BYTE_LAST_BIT = 5'd7;
  localparam logic [BIT_W-1:0] WORD_LAST_BIT = 5'd31;

endpackage

[sv/lsd_pixel_if.sv]
`timescale 1ns / 1ps
interface lsd_pixel_if;
  import lsd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pixel_byte;
  logic              frame_start;

  modport source (output valid, output pixel_byte, output frame_start, input ready);
  modport sink   (input valid, input pixel_byte, input frame_start, output ready);
endinterface

[sv/lsd_result_if.sv]
`timescale 1ns / 1ps
interface lsd_result_if;
  import lsd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [KIND_W-1:0] kind;
  logic              last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

[sv/lsb_stego_stream_decoder_top.sv]
`timescale 1ns / 1ps
// LSB stego stream decoder.
// pixels: one image byte per request, frame_start marks the first byte of an
//   image and restarts the parse with that same byte.
// results: extension bytes, payload bytes (last on the final one), a magic
//   mismatch error or an empty-payload end marker, at most one per byte.
// APB port: header_skip at 0x0, magic_char_a at 0x4, magic_char_b at 0x8;
//   pready is always high, write only while no request is in flight.
// Throughput: one pixel byte per cycle while pixels.ready is high. Each byte
//   updates the parse state in one step; the bit gather and length counters sit in it.
// Output: a result appears on results in the cycle after the byte that
//   completes it is accepted, held in the output register.
// Stall: while an unread result sits in the output register and the receiver
//   holds ready low, pixels.ready drops; otherwise bytes are taken every cycle.
// Reset: header_skip 54, magic "#*", parse at the header skip, output empty.
`include "lsb_stego_stream_decoder_top_macros.svh"
module lsb_stego_stream_decoder_top (
  input  logic                         clk,
  input  logic                         rst,
  lsd_pixel_if.sink                    pixels,
  lsd_result_if.source                 results,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsd_pkg::PADDR_W-1:0] paddr,
  input  logic [lsd_pkg::PDATA_W-1:0] pwdata,
  output logic [lsd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import lsd_pkg::*;

  // Configuration registers
  logic [SKIP_W-1:0] header_skip;
  logic [BYTE_W-1:0] magic_char_a;
  logic [BYTE_W-1:0] magic_char_b;

  // Parse state
  logic [2:0]        phase, phase_next;
  logic [BIT_W-1:0]  bit_index, bit_index_next;
  logic [WORD_W-1:0] shift_word, shift_word_next;
  logic [WORD_W-1:0] remaining_count, remaining_count_next;
  logic              magic_position, magic_position_next;
  logic              magic_ok, magic_ok_next;

  // Output register
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic [KIND_W-1:0] out_kind;
  logic              out_last;

  // Step results
  logic              emit;
  logic [BYTE_W-1:0] emit_byte;
  logic [KIND_W-1:0] emit_kind;
  logic              emit_last;

  // Working copies after a frame start
  logic [2:0]        cur_phase;
  logic [BIT_W-1:0]  cur_index;
  logic [WORD_W-1:0] cur_word;
  logic [WORD_W-1:0] cur_count;
  logic              cur_pos;
  logic              cur_ok;
  logic [WORD_W-1:0] gathered;
  logic [BYTE_W-1:0] expected;
  logic              magic_ok_upd;
  logic              byte_done;
  logic              word_done;
  logic              in_acc;
  logic              cfg_wr;

  assign in_acc       = pixels.valid && pixels.ready;
  assign pixels.ready = !out_valid || results.ready;
  assign cfg_wr       = psel && penable && pwrite && pready;
  assign pready       = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      header_skip  <= HEADER_SKIP_RST;
      magic_char_a <= MAGIC_CHAR_A_RST;
      magic_char_b <= MAGIC_CHAR_B_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_HEADER_SKIP:  header_skip  <= pwdata[SKIP_W-1:0];
        REG_MAGIC_CHAR_A: magic_char_a <= pwdata[BYTE_W-1:0];
        REG_MAGIC_CHAR_B: magic_char_b <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[3:2])
      REG_HEADER_SKIP:  prdata = {{(PDATA_W-SKIP_W){1'b0}}, header_skip};
      REG_MAGIC_CHAR_A: prdata = {{(PDATA_W-BYTE_W){1'b0}}, magic_char_a};
      REG_MAGIC_CHAR_B: prdata = {{(PDATA_W-BYTE_W){1'b0}}, magic_char_b};
      default:          prdata = '0;
    endcase
  end

  // Clear the parse view on a frame start
  always_comb begin
    if (pixels.frame_start) begin
      cur_phase = PH_HEADER;
      cur_index = '0;
      cur_word  = '0;
      cur_count = '0;
      cur_pos   = 1'b0;
      cur_ok    = 1'b1;
    end else begin
      cur_phase = phase;
      cur_index = bit_index;
      cur_word  = shift_word;
      cur_count = remaining_count;
      cur_pos   = magic_position;
      cur_ok    = magic_ok;
    end
  end

  // Gather one hidden bit
  assign gathered     = cur_word | ({{(WORD_W-1){1'b0}}, pixels.pixel_byte[0]} << cur_index);
  assign byte_done    = (cur_index == BYTE_LAST_BIT);
  assign word_done    = (cur_index == WORD_LAST_BIT);
  assign expected     = cur_pos ? magic_char_b : magic_char_a;
  assign magic_ok_upd = cur_ok && (gathered[BYTE_W-1:0] == expected);

  // Advance the parse by one byte
  always_comb begin
    phase_next           = cur_phase;
    bit_index_next       = cur_index + 5'd1;
    shift_word_next      = gathered;
    remaining_count_next = cur_count;
    magic_position_next  = cur_pos;
    magic_ok_next        = cur_ok;
    emit                 = 1'b0;
    emit_byte            = '0;
    emit_kind            = KIND_EXT;
    emit_last            = 1'b0;

    if (cur_phase == PH_HEADER && cur_count < {{(WORD_W-SKIP_W){1'b0}}, header_skip}) begin
      // Skip a header byte
      remaining_count_next = cur_count + 32'd1;
      bit_index_next       = cur_index;
      shift_word_next      = cur_word;
    end else begin
      unique case (cur_phase) inside
        PH_HEADER, PH_MAGIC: begin
          if (cur_phase == PH_HEADER) begin
            remaining_count_next = '0;
            phase_next           = PH_MAGIC;
          end
          if (byte_done) begin
            bit_index_next  = '0;
            shift_word_next = '0;
            magic_ok_next   = magic_ok_upd;
            if (!cur_pos) begin
              magic_position_next = 1'b1;
            end else if (magic_ok_upd) begin
              phase_next = PH_EXTLEN;
            end else begin
              phase_next = PH_IDLE;
              emit       = 1'b1;
              emit_kind  = KIND_ERR;
              emit_last  = 1'b1;
            end
          end
        end
        PH_EXTLEN: begin
          if (word_done) begin
            bit_index_next       = '0;
            shift_word_next      = '0;
            remaining_count_next = gathered;
            phase_next           = (gathered == '0) ? PH_PAYLEN : PH_EXT;
          end
        end
        PH_EXT: begin
          if (byte_done) begin
            bit_index_next       = '0;
            shift_word_next      = '0;
            remaining_count_next = cur_count - 32'd1;
            if (cur_count == 32'd1) begin
              phase_next = PH_PAYLEN;
            end
            emit      = 1'b1;
            emit_byte = gathered[BYTE_W-1:0];
            emit_kind = KIND_EXT;
          end
        end
        PH_PAYLEN: begin
          if (word_done) begin
            bit_index_next       = '0;
            shift_word_next      = '0;
            remaining_count_next = gathered;
            if (gathered == '0) begin
              phase_next = PH_IDLE;
              emit       = 1'b1;
              emit_kind  = KIND_END;
              emit_last  = 1'b1;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          if (byte_done) begin
            bit_index_next       = '0;
            shift_word_next      = '0;
            remaining_count_next = cur_count - 32'd1;
            emit                 = 1'b1;
            emit_byte            = gathered[BYTE_W-1:0];
            emit_kind            = KIND_PAY;
            if (cur_count == 32'd1) begin
              phase_next = PH_IDLE;
              emit_last  = 1'b1;
            end
          end
        end
        default: begin
          // Idle: hold everything until the next frame start
          bit_index_next  = cur_index;
          shift_word_next = cur_word;
        end
      endcase
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      bit_index       <= '0;
      shift_word      <= '0;
      remaining_count <= '0;
      magic_position  <= 1'b0;
      magic_ok        <= 1'b1;
    end else if (in_acc) begin
      phase           <= phase_next;
      bit_index       <= bit_index_next;
      shift_word      <= shift_word_next;
      remaining_count <= remaining_count_next;
      magic_position  <= magic_position_next;
      magic_ok        <= magic_ok_next;
    end
  end

  // Output register: load a new result, drop one that was taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_byte <= emit_byte;
      out_kind <= emit_kind;
      out_last <= emit_last;
    end
  end

  assign results.valid    = out_valid;
  assign results.out_byte = out_byte;
  assign results.kind     = out_kind;
  assign results.last     = out_last;

  // Checks
  `LSD_ASSERT_IMP(a_stall_only_on_full, !pixels.ready, out_valid && !results.ready,
                  "input stalled without a pending result")
  `LSD_ASSERT_NXT(a_emit_lands, in_acc && emit, out_valid, "emitted result not presented")
  `LSD_ASSERT_NXT(a_idle_sticks, in_acc && !pixels.frame_start && phase == PH_IDLE,
                  phase == PH_IDLE, "parse left idle without frame start")
  `LSD_ASSERT_IMP(a_byte_index, phase == PH_MAGIC || phase == PH_EXT || phase == PH_PAYLOAD,
                  bit_index <= BYTE_LAST_BIT, "bit index past a byte")

endmodule
